>>> rtl/pit_pkg.sv
// Package: command and status codes, sequencer helpers for the ping identifier table.
package pit_pkg;

	localparam int CMD_W = 3;
	localparam int SLOT_W = 6;
	localparam int ID_W = 16;
	localparam int STATUS_W = 2;

	localparam logic [CMD_W-1:0] CMD_OPEN = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_BIND = 3'd2;
	localparam logic [CMD_W-1:0] CMD_UNBIND = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_OPEN = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FAMILY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_IN_USE = 2'd3;

	// Auto-pick gives up after this many candidates.
	localparam logic [ID_W-1:0] MAX_ATTEMPTS = 16'hFFFF;
	localparam logic [ID_W-1:0] CAND_RESET = 16'd1;

	// Write controls toward the slot store.
	typedef struct packed {
		logic id_we;
		logic open_we;
		logic open_val;
	} pit_wr_t;

	function automatic logic [ID_W-1:0] swap16(input logic [ID_W-1:0] v);
		swap16 = {v[7:0], v[15:8]};
	endfunction

endpackage

>>> rtl/pit_if.sv
// Interfaces: request and result channels of the ping identifier table.
interface pit_req_if;
	logic valid;
	logic ready;
	logic [2:0] command;
	logic [5:0] slot;
	logic [15:0] requested_id;
	logic family_is_inet;
	logic [15:0] reply_id;

	modport source (output valid, command, slot, requested_id, family_is_inet, reply_id,
		input ready);
	modport sink (input valid, command, slot, requested_id, family_is_inet, reply_id,
		output ready);
endinterface

interface pit_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [15:0] assigned_id;
	logic matched;
	logic [5:0] matched_slot;

	modport source (output valid, status, assigned_id, matched, matched_slot, input ready);
	modport sink (input valid, status, assigned_id, matched, matched_slot, output ready);
endinterface

>>> rtl/pit_store.sv
// Slot store: open flags in flip-flops and the identifier memory with one registered read port.
module pit_store #(
	parameter int SLOTS = 64
) (
	input logic clk,
	input logic arst_n,
	input pit_pkg::pit_wr_t wr,
	input logic [$clog2(SLOTS)-1:0] wr_addr,
	input logic wr_in_range,
	input logic [15:0] wr_id,
	output logic open_at,
	input logic [$clog2(SLOTS)-1:0] rd_addr,
	output logic [15:0] rd_id_s1,
	output logic rd_open_s1
);
	import pit_pkg::*;

	logic [SLOTS-1:0] open_q;
	logic [ID_W-1:0] id_mem [SLOTS];

	// Out-of-range slots never read as open.
	assign open_at = wr_in_range && open_q[wr_addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
			rd_open_s1 <= 1'b0;
		end else begin
			if (wr.open_we && wr_in_range) begin
				open_q[wr_addr] <= wr.open_val;
			end
			rd_open_s1 <= open_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.id_we && wr_in_range) begin
			id_mem[wr_addr] <= wr_id;
		end
		rd_id_s1 <= id_mem[rd_addr];
	end

endmodule

>>> rtl/ping_identifier_table.sv
// Top level: ping identifier table with a sequenced slot scan over one memory read port.
//
// The table holds SLOTS ping-socket slots, each with an open flag and a 16-bit echo
// identifier. Every request word yields exactly one result word. Open, close, unbind, a
// bind that fails its slot or family check, a lookup of identifier zero and unused codes
// pass from accept to the done state and on to the output register. A lookup and a
// bind with a nonzero identifier sweep the identifier memory once, one entry per cycle
// through its single registered read port, ending early on a hit. A bind that asks
// for identifier zero tries candidates from a byte-swapped counter; every candidate
// passes through the attempt state and, when it is nonzero, a full or partial sweep,
// for at most 65535 candidates. The request channel is ready only while the
// sequencer is idle; a finished result waits in the output register, so the next
// request word can be taken while the previous result is still unclaimed. The
// identifier memory needs no clearing pass: an entry is only trusted while its slot's
// open flag is set, and opening a slot writes its identifier to zero.
module ping_identifier_table #(
	parameter int SLOTS = 64
) (
	input logic clk,
	input logic arst_n,
	pit_req_if.sink request,
	pit_rsp_if.source result
);
	import pit_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_ATTEMPT = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;
	logic [CMD_W-1:0] cmd_q;
	logic auto_q;
	logic [IW-1:0] slot_idx_q;
	logic [ID_W-1:0] target_q;
	logic [ID_W-1:0] cand_q;
	logic [ID_W-1:0] att_q;

	// Scan counter and the read that is in flight.
	logic [IW-1:0] cnt_q;
	logic last_issued_q;
	logic chk_s1;
	logic [IW-1:0] idx_s1;

	// Result being built, then the output register.
	logic [STATUS_W-1:0] res_status_q;
	logic [ID_W-1:0] res_id_q;
	logic res_match_q;
	logic [SLOT_W-1:0] res_mslot_q;
	logic out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ID_W-1:0] out_id_q;
	logic out_match_q;
	logic [SLOT_W-1:0] out_mslot_q;

	logic accept;
	logic in_range;
	logic open_at;
	pit_wr_t wr;
	logic [IW-1:0] wr_addr;
	logic wr_in_range;
	logic [ID_W-1:0] wr_id;
	logic [ID_W-1:0] rd_id_s1;
	logic rd_open_s1;
	logic issue;
	logic hit;
	logic scan_end;
	logic [ID_W-1:0] cand_swapped;

	assign request.ready = (state_q == S_IDLE);
	assign accept = request.valid && request.ready;
	assign in_range = 32'(request.slot) < SLOTS;

	// One compare per cycle against the entry read the cycle before.
	assign issue = (state_q == S_SCAN) && !last_issued_q;
	assign hit = chk_s1 && rd_open_s1 && (rd_id_s1 == target_q);
	assign scan_end = chk_s1 && (hit || idx_s1 == LAST_IDX);
	assign cand_swapped = swap16(cand_q);

	// Store write port: idle-time slot updates, or the bind write at the end of a clean scan.
	always_comb begin
		wr = '0;
		wr_addr = IW'(request.slot);
		wr_in_range = in_range;
		wr_id = '0;
		if (state_q == S_IDLE) begin
			if (accept) begin
				case (request.command)
					CMD_OPEN: begin
						wr.id_we = 1'b1;
						wr.open_we = 1'b1;
						wr.open_val = 1'b1;
					end
					CMD_CLOSE: begin
						wr.open_we = 1'b1;
						wr.open_val = 1'b0;
					end
					CMD_UNBIND: begin
						wr.id_we = open_at;
					end
					default: begin
						wr = '0;
					end
				endcase
			end
		end else begin
			wr_addr = slot_idx_q;
			wr_in_range = 1'b1;
			wr_id = target_q;
			wr.id_we = (state_q == S_SCAN) && scan_end && !hit && (cmd_q == CMD_BIND);
		end
	end

	pit_store #(
		.SLOTS(SLOTS)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.wr_addr(wr_addr),
		.wr_in_range(wr_in_range),
		.wr_id(wr_id),
		.open_at(open_at),
		.rd_addr(cnt_q),
		.rd_id_s1(rd_id_s1),
		.rd_open_s1(rd_open_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= CMD_OPEN;
			auto_q <= 1'b0;
			slot_idx_q <= '0;
			target_q <= '0;
			cand_q <= CAND_RESET;
			att_q <= '0;
			cnt_q <= '0;
			last_issued_q <= 1'b0;
			chk_s1 <= 1'b0;
			idx_s1 <= '0;
			res_status_q <= ST_OK;
			res_id_q <= '0;
			res_match_q <= 1'b0;
			res_mslot_q <= '0;
			out_valid_q <= 1'b0;
			out_status_q <= ST_OK;
			out_id_q <= '0;
			out_match_q <= 1'b0;
			out_mslot_q <= '0;
		end else begin
			chk_s1 <= 1'b0;
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= request.command;
						slot_idx_q <= IW'(request.slot);
						res_status_q <= ST_OK;
						res_id_q <= '0;
						res_match_q <= 1'b0;
						res_mslot_q <= '0;
						cnt_q <= '0;
						last_issued_q <= 1'b0;
						auto_q <= 1'b0;
						state_q <= S_DONE;
						case (request.command)
							CMD_BIND: begin
								if (!open_at) begin
									res_status_q <= ST_NOT_OPEN;
								end else if (!request.family_is_inet) begin
									res_status_q <= ST_FAMILY;
								end else if (request.requested_id != '0) begin
									target_q <= request.requested_id;
									state_q <= S_SCAN;
								end else begin
									auto_q <= 1'b1;
									att_q <= '0;
									state_q <= S_ATTEMPT;
								end
							end
							CMD_UNBIND: begin
								if (!open_at) begin
									res_status_q <= ST_NOT_OPEN;
								end
							end
							CMD_LOOKUP: begin
								if (request.reply_id != '0) begin
									target_q <= request.reply_id;
									state_q <= S_SCAN;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_ATTEMPT: begin
					// Give up once every attempt is spent; else take one candidate, skipping zero without a sweep.
					if (att_q == MAX_ATTEMPTS) begin
						res_status_q <= ST_IN_USE;
						state_q <= S_DONE;
					end else begin
						att_q <= att_q + 16'd1;
						cand_q <= cand_q + 16'd1;
						if (cand_swapped != '0) begin
							target_q <= cand_swapped;
							cnt_q <= '0;
							last_issued_q <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (issue && !scan_end) begin
						chk_s1 <= 1'b1;
						idx_s1 <= cnt_q;
						if (cnt_q == LAST_IDX) begin
							last_issued_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					if (scan_end) begin
						state_q <= S_DONE;
						if (cmd_q == CMD_LOOKUP) begin
							res_match_q <= hit;
							res_mslot_q <= hit ? SLOT_W'(idx_s1) : '0;
						end else if (!hit) begin
							res_id_q <= target_q;
						end else if (auto_q) begin
							// Candidate held by an open slot: try the next one.
							state_q <= S_ATTEMPT;
						end else begin
							res_status_q <= ST_IN_USE;
						end
					end
				end
				S_DONE: begin
					// Hand over once the output register is free.
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_status_q <= res_status_q;
						out_id_q <= res_id_q;
						out_match_q <= res_match_q;
						out_mslot_q <= res_mslot_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result.valid = out_valid_q;
	assign result.status = out_status_q;
	assign result.assigned_id = out_id_q;
	assign result.matched = out_match_q;
	assign result.matched_slot = out_mslot_q;

	// An accepted word always leaves the sequencer busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("sequencer idle right after an accept");

	// A bind only ever writes an identifier into an open slot.
	a_bind_open_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.id_we && state_q == S_SCAN) |-> open_at)
		else $error("bind wrote identifier into a closed slot");

	// A nonzero identifier is only reported with an ok status.
	a_assigned_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.assigned_id != '0) |-> result.status == ST_OK)
		else $error("assigned identifier with a failing status");

endmodule
